>>> rtl/core/kvt_pkg.sv
// ---------------------------------------------------------------------------
// kvt_pkg
// Shared widths, request and status codes, and the controller/datapath
// command and status bundles of the keyed value table.
// ---------------------------------------------------------------------------
package kvt_pkg;

   // Field widths of the request and result items
   localparam int COMMAND_W = 2;
   localparam int KEY_W     = 32;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;

   // Request codes
   localparam logic [COMMAND_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE  = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_REPLACE = 2'd2;
   localparam logic [COMMAND_W-1:0] CMD_FIND    = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STS_DUP    = 2'd1;
   localparam logic [STATUS_W-1:0] STS_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL   = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture the accepted item, clear scan results
      logic issue;   // read the slot at the scan address
      logic commit;  // apply the update and load the result register
   } kvt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // result register can take a new item this cycle
   } kvt_sts_type;

endpackage

>>> rtl/core/kvt_ctrl.sv
// ---------------------------------------------------------------------------
// kvt_ctrl
// Sequencer for one request: accept, scan every slot through the memory
// read port, let the last compare settle, then commit the result.
// ---------------------------------------------------------------------------
module kvt_ctrl #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output kvt_pkg::kvt_cmd_type cmd,
   output logic [IDX_W-1:0]    rd_addr,
   input  kvt_pkg::kvt_sts_type sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_EXEC = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (scan_ff == LAST_IDX) begin
               state_in = ST_WAIT;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            // last slot compare lands this cycle
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

>>> rtl/core/kvt_datapath.sv
// ---------------------------------------------------------------------------
// kvt_datapath
// Slot memories, valid bits, live count, key compare against the slot read
// back each scan cycle, the update at commit and the result register.
// ---------------------------------------------------------------------------
module kvt_datapath #(
   parameter int ENTRIES     = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX_W       = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  kvt_pkg::kvt_cmd_type                  cmd,
   input  logic [IDX_W-1:0]                      rd_addr,
   output kvt_pkg::kvt_sts_type                  sts,
   input  logic [kvt_pkg::COMMAND_W-1:0]         req_command,
   input  logic signed [kvt_pkg::KEY_W-1:0]      req_lookup_key,
   input  logic [kvt_pkg::DATA_W-1:0]            req_entry_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [kvt_pkg::DATA_W-1:0]            rsp_read_value,
   output logic [kvt_pkg::STATUS_W-1:0]          rsp_status,
   output logic [kvt_pkg::COUNT_W-1:0]           rsp_entry_count
);

   localparam int KW    = kvt_pkg::KEY_W;
   localparam int DW    = kvt_pkg::DATA_W;
   localparam int CW    = kvt_pkg::COUNT_W;
   // stored value bits: the value field never carries more than DW bits
   localparam int SW    = (VALUE_WIDTH < DW) ? VALUE_WIDTH : DW;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Slot storage
   logic signed [KW-1:0] key_mem [ENTRIES];
   logic [SW-1:0]        val_mem [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // Captured request
   logic [kvt_pkg::COMMAND_W-1:0] command_ff;
   logic signed [KW-1:0]          key_ff;
   logic [SW-1:0]                 value_ff;

   // Scan pipeline and results
   logic signed [KW-1:0] key_rd_ff;
   logic [SW-1:0]        val_rd_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 cmp_vld_ff;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [SW-1:0]        hit_val_ff, hit_val_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff;
   logic [DW-1:0]                     read_value_ff;
   logic [kvt_pkg::STATUS_W-1:0]      status_ff;
   logic [CW-1:0]                     entry_count_ff;

   // Commit decode
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic                         set_valid;
   logic                         clr_valid;
   logic [kvt_pkg::STATUS_W-1:0] status_c;
   logic [DW-1:0]                read_c;

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         key_ff     <= req_lookup_key;
         value_ff   <= req_entry_value[SW-1:0];
      end
   end

   // Slot memories: read during the scan, written at commit
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         key_mem[wr_addr] <= key_ff;
         val_mem[wr_addr] <= value_ff;
      end
      if (cmd.issue) begin
         key_rd_ff <= key_mem[rd_addr];
         val_rd_ff <= val_mem[rd_addr];
      end
      cmp_idx_ff <= rd_addr;
   end

   // Compare the slot read back against the request key
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_val_in  = hit_val_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmp_vld_ff) begin
         if (valid_ff[cmp_idx_ff] && (key_rd_ff == key_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
            hit_val_in = val_rd_ff;
         end
         // lowest free slot wins
         if (!valid_ff[cmp_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_idx_ff <= free_idx_in;
   end

   // Update decode per request code
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = free_idx_ff;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      count_in  = count_ff;
      status_c  = kvt_pkg::STS_OK;
      read_c    = '0;
      case (command_ff)
         kvt_pkg::CMD_INSERT: begin
            if (hit_ff) begin
               status_c = kvt_pkg::STS_DUP;
            end else if (free_ff) begin
               wr_en     = 1'b1;
               set_valid = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end else begin
               status_c = kvt_pkg::STS_FULL;
            end
         end
         kvt_pkg::CMD_REMOVE: begin
            if (hit_ff) begin
               clr_valid = 1'b1;
               count_in  = count_ff - CNT_W'(1);
            end else begin
               status_c = kvt_pkg::STS_ABSENT;
            end
         end
         kvt_pkg::CMD_REPLACE: begin
            if (hit_ff) begin
               wr_en   = 1'b1;
               wr_addr = hit_idx_ff;
            end else if (free_ff) begin
               wr_en     = 1'b1;
               set_valid = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end else begin
               status_c = kvt_pkg::STS_FULL;
            end
         end
         kvt_pkg::CMD_FIND: begin
            if (hit_ff) begin
               read_c = DW'(hit_val_ff);
            end
         end
         default: begin
            status_c = kvt_pkg::STS_OK;
         end
      endcase
   end

   // Valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && set_valid) begin
         valid_in[free_idx_ff] = 1'b1;
      end
      if (cmd.commit && clr_valid) begin
         valid_in[hit_idx_ff] = 1'b0;
      end
   end

   // Result register handshake
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         found_ff       <= hit_ff;
         read_value_ff  <= read_c;
         status_ff      <= status_c;
         entry_count_ff <= CW'(count_in);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= cmd.commit ? count_in : count_ff;
         cmp_vld_ff   <= cmd.issue;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;

   // Live count tracks the valid bits
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      CNT_W'($countones(valid_ff)) == count_ff)
      else $error("live count disagrees with valid bits");

   // Never overwrite a result that is still held
   a_commit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("commit while result register is stalled");

   // A commit always presents an item next cycle
   a_commit_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed item not presented");

   // A matching slot is never also reported as free
   a_hit_not_free: assert property (@(posedge clock) disable iff (reset)
      (hit_ff && free_ff) |-> (hit_idx_ff != free_idx_ff))
      else $error("hit slot also marked free");

endmodule

>>> rtl/core/keyed_value_table_core.sv
// ---------------------------------------------------------------------------
// keyed_value_table_core
// Bounded table of unique signed 32-bit keys, each with a value. Requests
// insert, remove, replace-or-insert or find a key; every result carries the
// found flag, the value on a find hit, a status code and the live entry
// count after the request. After acceptance the key is compared against one
// slot per cycle as the scan walks the single read port of the slot memory,
// a wait state lets the last compare settle and the execute state applies the
// update once the result register is free. One item is worked on at a time;
// the next is accepted in the cycle after the result is registered, while
// that result may still wait to be taken. Valid bits clear at reset, so no
// clearing pass is needed.
// ---------------------------------------------------------------------------
module keyed_value_table_core #(
   parameter int ENTRIES     = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kvt_pkg::COMMAND_W-1:0]     req_command,
   input  logic signed [kvt_pkg::KEY_W-1:0]  req_lookup_key,
   input  logic [kvt_pkg::DATA_W-1:0]        req_entry_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [kvt_pkg::DATA_W-1:0]        rsp_read_value,
   output logic [kvt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [kvt_pkg::COUNT_W-1:0]       rsp_entry_count
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   kvt_pkg::kvt_cmd_type cmd;
   kvt_pkg::kvt_sts_type sts;
   logic [IDX_W-1:0]     rd_addr;

   // Sequencer
   kvt_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .sts       (sts)
   );

   // Storage, compare and result register
   kvt_datapath #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .sts             (sts),
      .req_command     (req_command),
      .req_lookup_key  (req_lookup_key),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
